// File: rtl/matrix3x3_inverse_unit_defines.svh
// Assertion macros for the 3x3 matrix inverse unit.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define M3I_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("m3i assertion failed");

// A stalled transfer keeps its content until the receiver takes it.
`define M3I_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) \
    else $error("m3i stalled transfer changed");

`endif

// File: rtl/m3i_pkg.sv
// Shared constants for the 3x3 matrix inverse unit.
// No dependencies.
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int unsigned QW = 24;
  localparam logic signed [QW-1:0] QMAX = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] QMIN = -24'sh800000;
endpackage

// File: rtl/matrix3x3_inverse_unit.sv
// 3x3 matrix inverse by adjugate: top level with nine divider lanes and merge.
// Depends on m3i_pkg, m3i_cofactor, m3i_lane and the defines header.
//
// Channel  | Dir | Content
// s_axis   | in  | tdata: nine signed elements, r0c0 lowest, row-major
// m_axis   | out | tdata: nine 24-bit results, r0c0 lowest; tuser: singular, clipped
//
// One matrix is taken every cycle while the pipeline advances; the pipe holds
// the cofactor and determinant stages, then the lane input register and the
// 25-stage restoring divide in each lane. It advances as one whenever the output
// register is empty or being drained, so a stall downstream freezes every stage
// in place. Reset clears only the valid bits.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_unit_defines.svh"
module matrix3x3_inverse_unit #(
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (lowest first)
  input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_r0c0 .. out_r2c2, 24 bits each (lowest first)
  output logic [215:0]                 m_axis_tdata,
  // singular, clipped
  output logic [1:0]                   m_axis_tuser
);
  localparam int unsigned EW = ELEMENT_WIDTH;
  localparam int unsigned AW = 2*EW + 1;
  localparam int unsigned DW = 3*EW + 2;
  localparam int unsigned LAT = 2 + m3i_pkg::QW + 2;

  logic adv;
  logic [LAT-1:0] vld_q;
  logic signed [AW-1:0] adj [9];
  logic signed [DW-1:0] det;
  logic [m3i_pkg::QW-1:0] q [9];
  logic [8:0] clip;
  logic [LAT-3:0] sing_q;

  // The whole pipe moves when the last slot is empty or being taken.
  assign adv = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  m3i_cofactor #(.EW(EW)) u_cof (
    .clk_i, .en_i(adv), .m_i(s_axis_tdata[9*EW-1:0]), .adj_o(adj), .det_o(det)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_lane #(.AW(AW), .DW(DW), .FS(EW+12)) u_lane (
      .clk_i, .en_i(adv), .adj_i(adj[k]), .det_i(det), .q_o(q[k]), .clip_o(clip[k])
    );
  end

  // Singular flag rides alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (adv) sing_q <= {sing_q[LAT-4:0], det == '0};
  end

  // Merge: zero on singular, gather clip flags.
  logic sing;
  assign sing = sing_q[LAT-3];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_axis_tdata[k*24 +: 24] = sing ? 24'd0 : q[k];
    end
    m_axis_tuser = {(!sing) && (|clip), sing};
  end

  `M3I_ASSERT(a_in_gap, (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
  `M3I_ASSERT(a_out_flags, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
  `M3I_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
  `M3I_HOLD(a_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)
endmodule

// File: rtl/m3i_lane.sv
// One division lane: |adj| << FS / |det| restoring, one quotient bit per stage.
// Uses m3i_pkg for output width and saturation limits.
`timescale 1ns / 1ps
module m3i_lane #(
  parameter int unsigned AW = 33,
  parameter int unsigned DW = 50,
  parameter int unsigned FS = 28
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [AW-1:0]        adj_i,
  input  logic signed [DW-1:0]        det_i,
  output logic signed [m3i_pkg::QW-1:0] q_o,
  output logic                        clip_o
);
  localparam int unsigned NS = m3i_pkg::QW + 1;
  localparam int unsigned NW = AW + FS + 1;
  localparam int unsigned RW = NW + 1;

  logic [NW-1:0] num_q [NS+1];
  logic [RW-1:0] den_q [NS+1];
  logic [NS-1:0] qb_q  [NS+1];
  logic          neg_q [NS+1];
  logic [AW-1:0] adj_abs;
  logic [DW-1:0] det_abs;

  // Magnitudes are taken at the operand width, where they always fit.
  assign adj_abs = adj_i[AW-1] ? AW'(-adj_i) : AW'(adj_i);
  assign det_abs = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= NW'(adj_abs) << FS;
      den_q[0] <= RW'(det_abs);
      qb_q[0]  <= '0;
      neg_q[0] <= adj_i[AW-1] ^ det_i[DW-1];
    end
  end

  // Stage s tests bit NS-1-s; the top bit stands for "at least 2^24".
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW+NS-1:0] t;
    logic             ge;
    assign t  = {{NS{1'b0}}, den_q[s]} << (NS-1-s);
    assign ge = {{(RW+NS-NW){1'b0}}, num_q[s]} >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= (ge && s != 0) ? num_q[s] - NW'(t) : num_q[s];
        qb_q[s+1]  <= qb_q[s] | (NS'(ge) << (NS-1-s));
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  logic [NS-1:0] q;
  assign q = qb_q[NS][NS-1] ? {1'b1, {(NS-1){1'b0}}} : qb_q[NS];
  always_comb begin
    clip_o = 1'b0;
    if (neg_q[NS]) begin
      if (q > NS'(24'h800000)) begin
        q_o = m3i_pkg::QMIN; clip_o = 1'b1;
      end else begin
        q_o = -m3i_pkg::QW'(q);
      end
    end else if (q > NS'(24'h7FFFFF)) begin
      q_o = m3i_pkg::QMAX; clip_o = 1'b1;
    end else begin
      q_o = m3i_pkg::QW'(q);
    end
  end
endmodule

// File: rtl/m3i_cofactor.sv
// Cofactor and determinant front end: two register stages.
// No package dependency.
`timescale 1ns / 1ps
module m3i_cofactor #(
  parameter int unsigned EW = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [9*EW-1:0]       m_i,
  output logic signed [2*EW:0]  adj_o [9],
  output logic signed [3*EW+1:0] det_o
);
  localparam int unsigned AW = 2*EW + 1;
  localparam int unsigned DW = 3*EW + 2;
  logic signed [EW-1:0] e [9];
  logic signed [AW-1:0] adj_q [9];
  logic signed [EW-1:0] c0_q, c1_q, c2_q;
  for (genvar k = 0; k < 9; k++) begin : g_e
    assign e[k] = m_i[k*EW +: EW];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adj_q[0] <= AW'(e[4]*e[8]) - AW'(e[5]*e[7]);
      adj_q[1] <= AW'(e[2]*e[7]) - AW'(e[1]*e[8]);
      adj_q[2] <= AW'(e[1]*e[5]) - AW'(e[2]*e[4]);
      adj_q[3] <= AW'(e[5]*e[6]) - AW'(e[3]*e[8]);
      adj_q[4] <= AW'(e[0]*e[8]) - AW'(e[2]*e[6]);
      adj_q[5] <= AW'(e[2]*e[3]) - AW'(e[0]*e[5]);
      adj_q[6] <= AW'(e[3]*e[7]) - AW'(e[4]*e[6]);
      adj_q[7] <= AW'(e[1]*e[6]) - AW'(e[0]*e[7]);
      adj_q[8] <= AW'(e[0]*e[4]) - AW'(e[1]*e[3]);
      c0_q <= e[0]; c1_q <= e[1]; c2_q <= e[2];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) adj_o[k] <= adj_q[k];
      det_o <= DW'(c0_q*adj_q[0]) + DW'(c1_q*adj_q[3]) + DW'(c2_q*adj_q[6]);
    end
  end
endmodule
